// ===== hdl/mbrtu_pkg.sv =====
package mbrtu_pkg;

  // Table geometry
  localparam int TBL_N  = 32;
  localparam int TBL_AW = $clog2(TBL_N);

  // CRC-16, reflected
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Coil write values
  localparam logic [15:0] COIL_ON  = 16'hFF00;
  localparam logic [15:0] COIL_OFF = 16'h0000;
  localparam logic [7:0]  EXC_FLAG = 8'h80;

  // Item opcodes
  localparam logic [2:0] OP_RX_BYTE   = 3'd0;
  localparam logic [2:0] OP_FRAME_END = 3'd1;
  localparam logic [2:0] OP_TX_READY  = 3'd2;
  localparam logic [2:0] OP_SET_INPUT = 3'd3;
  localparam logic [2:0] OP_SET_DISC  = 3'd4;
  localparam logic [2:0] OP_RD_HOLD   = 3'd5;
  localparam logic [2:0] OP_RD_COIL   = 3'd6;

  // Function codes
  localparam logic [7:0] FN_RD_COILS = 8'd1;
  localparam logic [7:0] FN_RD_DISC  = 8'd2;
  localparam logic [7:0] FN_RD_HOLD  = 8'd3;
  localparam logic [7:0] FN_RD_INPUT = 8'd4;
  localparam logic [7:0] FN_WR_COIL  = 8'd5;
  localparam logic [7:0] FN_WR_HOLD  = 8'd6;

  // Exception codes
  localparam logic [7:0] EXC_ILL_FN   = 8'd1;
  localparam logic [7:0] EXC_BAD_ADDR = 8'd2;
  localparam logic [7:0] EXC_BAD_VAL  = 8'd3;

  localparam logic [7:0] MIN_FRAME = 8'd8;
  localparam logic [7:0] RX_SAT    = 8'd255;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_BITS = 3'd1,
    KIND_REGS = 3'd2,
    KIND_ECHO = 3'd3,
    KIND_EXC1 = 3'd4,
    KIND_EXC2 = 3'd5,
    KIND_EXC3 = 3'd6
  } reply_kind_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  rx_byte;
    logic [4:0]  local_index;
    logic [15:0] local_value;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] read_value;
  } out_item_t;

  // One byte through the CRC-16 shift register
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/mbrtu_tbl.sv =====
module mbrtu_tbl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [mbrtu_pkg::TBL_AW-1:0] wr_addr,
  input  logic [15:0]                wr_data,
  input  logic                       rd_en,
  input  logic [mbrtu_pkg::TBL_AW-1:0] rd_addr,
  output logic [15:0]                rd_data
);
  import mbrtu_pkg::*;

  logic [15:0]      mem [TBL_N];
  logic [TBL_N-1:0] vld_r;
  logic [15:0]      rd_q_r;
  logic             rd_vld_r;

  // Mark entries written since reset; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : 16'h0000;

endmodule

// ===== hdl/modbus_rtu_slave.sv =====
// Modbus RTU slave with CRC-16. Every input beat is handled in two steps: the
// first reads the holding/input register tables (one synchronous memory each,
// registered read), the second updates the frame and reply state and writes
// back, and no new beat is taken while one is in process. A beat that yields a
// result (local read, or transmit tick with a reply pending) is held in an output
// register; other beats keep flowing while that result waits. The tables come
// out of reset as zero through per-entry valid bits, so no clearing pass is needed.
module modbus_rtu_slave (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mbrtu_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mbrtu_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);
  import mbrtu_pkg::*;

  logic [7:0]       slave_r;
  logic             busy_r;
  in_item_t         item_r;
  logic [7:0]       head_r [6];
  logic [7:0]       head_nxt [6];
  logic [7:0]       rx_len_r, rx_len_nxt;
  logic [15:0]      rx_crc_r, rx_crc_nxt;
  logic             pending_r, pending_nxt;
  reply_kind_t      kind_r, kind_nxt;
  logic [15:0]      pos_r, pos_nxt;
  logic [15:0]      tx_crc_r, tx_crc_nxt;
  logic [TBL_N-1:0] coil_r, coil_nxt;
  logic [TBL_N-1:0] disc_r, disc_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             accept;
  logic             gives_res;
  logic [15:0]      addr_w, cnt_w;
  logic [16:0]      cnt_p7;
  logic [17:0]      plen;
  logic [15:0]      k_w;
  logic [16:0]      reg_a;
  logic             reg_in_rng;
  logic [TBL_AW-1:0] rd_addr;
  logic [15:0]      hold_rd, inp_rd, reg_word;
  logic             hold_we;
  logic             inp_we;
  logic [7:0]       bit_byte;
  logic [7:0]       pbyte;
  logic             start;
  reply_kind_t      start_kind;
  logic             coil_we, coil_val;

  // Handshake
  assign gives_res = (in_data.opcode == OP_RD_HOLD) || (in_data.opcode == OP_RD_COIL) ||
                     ((in_data.opcode == OP_TX_READY) && pending_r);
  assign in_stall  = busy_r || (out_valid_r && out_stall && gives_res);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Request fields
  assign addr_w = {head_r[2], head_r[3]};
  assign cnt_w  = {head_r[4], head_r[5]};
  assign cnt_p7 = {1'b0, cnt_w} + 17'd7;

  // Reply length without CRC
  always_comb begin
    case (kind_r)
      KIND_BITS: plen = 18'd3 + {4'h0, cnt_p7[16:3]};
      KIND_REGS: plen = 18'd3 + {1'b0, cnt_w, 1'b0};
      KIND_ECHO: plen = 18'd6;
      default:   plen = 18'd3;
    endcase
  end

  // Register word addressed by the current reply byte
  assign k_w        = pos_r - 16'd3;
  assign reg_a      = {1'b0, addr_w} + {2'b00, k_w[15:1]};
  assign reg_in_rng = reg_a < 17'(TBL_N);
  assign rd_addr    = (in_data.opcode == OP_RD_HOLD) ? in_data.local_index[TBL_AW-1:0]
                                                     : reg_a[TBL_AW-1:0];

  mbrtu_tbl u_hold (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (hold_we),
    .wr_addr (addr_w[TBL_AW-1:0]),
    .wr_data (cnt_w),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (hold_rd)
  );

  assign inp_we = busy_r && (item_r.opcode == OP_SET_INPUT);

  mbrtu_tbl u_inp (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (inp_we),
    .wr_addr (item_r.local_index[TBL_AW-1:0]),
    .wr_data (item_r.local_value),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (inp_rd)
  );

  assign reg_word = (head_r[1] == FN_RD_HOLD) ? hold_rd : inp_rd;

  // Pack up to eight coil or discrete bits for one reply byte
  always_comb begin
    logic [18:0] n;
    logic [19:0] a;
    bit_byte = 8'h00;
    for (int i = 0; i < 8; i++) begin
      n = {k_w, 3'(i)};
      a = {4'h0, addr_w} + {1'b0, n};
      if ((n < {3'b000, cnt_w}) && (a < 20'(TBL_N))) begin
        bit_byte[i] = (head_r[1] == FN_RD_COILS) ? coil_r[a[TBL_AW-1:0]]
                                                  : disc_r[a[TBL_AW-1:0]];
      end
    end
  end

  // Reply body byte at the current position
  always_comb begin
    pbyte = 8'h00;
    if (pos_r == 16'd0) begin
      pbyte = head_r[0];
    end else if (kind_r == KIND_ECHO) begin
      pbyte = (pos_r < 16'd6) ? head_r[pos_r[2:0]] : 8'h00;
    end else if (kind_r == KIND_EXC1 || kind_r == KIND_EXC2 || kind_r == KIND_EXC3) begin
      if (pos_r == 16'd1) begin
        pbyte = head_r[1] | EXC_FLAG;
      end else begin
        case (kind_r)
          KIND_EXC1: pbyte = EXC_ILL_FN;
          KIND_EXC2: pbyte = EXC_BAD_ADDR;
          default:   pbyte = EXC_BAD_VAL;
        endcase
      end
    end else if (pos_r == 16'd1) begin
      pbyte = head_r[1];
    end else if (kind_r == KIND_BITS) begin
      pbyte = (pos_r == 16'd2) ? cnt_p7[10:3] : bit_byte;
    end else begin
      if (pos_r == 16'd2) begin
        pbyte = {cnt_w[6:0], 1'b0};
      end else if (!reg_in_rng) begin
        pbyte = 8'h00;
      end else begin
        pbyte = k_w[0] ? reg_word[7:0] : reg_word[15:8];
      end
    end
  end

  // Frame check and dispatch at frame end
  always_comb begin
    logic good, bcast;
    logic [7:0] fn;
    good = !pending_r && (rx_len_r >= MIN_FRAME) && (rx_crc_r == 16'h0000) &&
           ((head_r[0] == slave_r) || (head_r[0] == 8'h00));
    fn         = head_r[1];
    bcast      = (head_r[0] == 8'h00);
    start      = 1'b0;
    start_kind = KIND_NONE;
    hold_we    = 1'b0;
    coil_we    = 1'b0;
    coil_val   = (cnt_w == COIL_ON);
    if (busy_r && (item_r.opcode == OP_FRAME_END) && good &&
        !(bcast && fn != FN_WR_COIL && fn != FN_WR_HOLD)) begin
      if (fn == FN_RD_COILS || fn == FN_RD_DISC || fn == FN_RD_HOLD || fn == FN_RD_INPUT) begin
        if (rx_len_r == MIN_FRAME) begin
          start = 1'b1;
          if ((cnt_w == 16'h0000) || (addr_w >= 16'(TBL_N)) ||
              ({1'b0, cnt_w} > (17'(TBL_N) - {1'b0, addr_w}))) begin
            start_kind = KIND_EXC2;
          end else if (fn == FN_RD_COILS || fn == FN_RD_DISC) begin
            start_kind = KIND_BITS;
          end else begin
            start_kind = KIND_REGS;
          end
        end
      end else if (fn == FN_WR_COIL || fn == FN_WR_HOLD) begin
        if (rx_len_r == MIN_FRAME) begin
          if (addr_w >= 16'(TBL_N)) begin
            start      = !bcast;
            start_kind = KIND_EXC2;
          end else if (fn == FN_WR_COIL) begin
            if (cnt_w != COIL_OFF && cnt_w != COIL_ON) begin
              start      = !bcast;
              start_kind = KIND_EXC3;
            end else begin
              coil_we    = 1'b1;
              start      = !bcast;
              start_kind = KIND_ECHO;
            end
          end else begin
            hold_we    = 1'b1;
            start      = !bcast;
            start_kind = KIND_ECHO;
          end
        end
      end else begin
        start      = 1'b1;
        start_kind = KIND_EXC1;
      end
    end
  end

  // Next state for the beat in process
  always_comb begin
    head_nxt      = head_r;
    rx_len_nxt    = rx_len_r;
    rx_crc_nxt    = rx_crc_r;
    pending_nxt   = pending_r;
    kind_nxt      = kind_r;
    pos_nxt       = pos_r;
    tx_crc_nxt    = tx_crc_r;
    coil_nxt      = coil_r;
    disc_nxt      = disc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (busy_r) begin
      case (item_r.opcode)
        OP_RX_BYTE: begin
          if (rx_len_r < 8'd6) head_nxt[rx_len_r[2:0]] = item_r.rx_byte;
          if (rx_len_r != RX_SAT) rx_len_nxt = rx_len_r + 8'd1;
          rx_crc_nxt = crc_step(rx_crc_r, item_r.rx_byte);
        end
        OP_FRAME_END: begin
          rx_len_nxt = 8'd0;
          rx_crc_nxt = CRC_INIT;
          if (coil_we) coil_nxt[addr_w[TBL_AW-1:0]] = coil_val;
          if (start) begin
            pending_nxt = 1'b1;
            kind_nxt    = start_kind;
            pos_nxt     = 16'd0;
            tx_crc_nxt  = CRC_INIT;
          end
        end
        OP_TX_READY: begin
          if (pending_r) begin
            out_valid_nxt       = 1'b1;
            out_nxt.result_kind = 1'b0;
            out_nxt.read_value  = 16'h0000;
            out_nxt.tx_last     = 1'b0;
            pos_nxt             = pos_r + 16'd1;
            if ({2'b00, pos_r} < plen) begin
              out_nxt.tx_byte = pbyte;
              tx_crc_nxt      = crc_step(tx_crc_r, pbyte);
            end else if ({2'b00, pos_r} == plen) begin
              out_nxt.tx_byte = tx_crc_r[7:0];
            end else begin
              out_nxt.tx_byte = tx_crc_r[15:8];
              out_nxt.tx_last = 1'b1;
              pending_nxt     = 1'b0;
              kind_nxt        = KIND_NONE;
              pos_nxt         = 16'd0;
            end
          end
        end
        OP_SET_DISC: begin
          disc_nxt[item_r.local_index[TBL_AW-1:0]] = item_r.local_value[0];
        end
        OP_RD_HOLD, OP_RD_COIL: begin
          out_valid_nxt       = 1'b1;
          out_nxt.result_kind = 1'b1;
          out_nxt.tx_byte     = 8'h00;
          out_nxt.tx_last     = 1'b0;
          out_nxt.read_value  = (item_r.opcode == OP_RD_HOLD) ? hold_rd :
                                {15'h0000, coil_r[item_r.local_index[TBL_AW-1:0]]};
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r     <= 8'd1;
      busy_r      <= 1'b0;
      rx_len_r    <= 8'd0;
      rx_crc_r    <= CRC_INIT;
      pending_r   <= 1'b0;
      kind_r      <= KIND_NONE;
      pos_r       <= 16'd0;
      tx_crc_r    <= CRC_INIT;
      coil_r      <= '0;
      disc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) slave_r <= cfg_wdata;
      busy_r      <= accept;
      rx_len_r    <= rx_len_nxt;
      rx_crc_r    <= rx_crc_nxt;
      pending_r   <= pending_nxt;
      kind_r      <= kind_nxt;
      pos_r       <= pos_nxt;
      tx_crc_r    <= tx_crc_nxt;
      coil_r      <= coil_nxt;
      disc_r      <= disc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: beat in process, request head, result
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    head_r <= head_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTHESIS
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r)
    else $error("beat accepted while previous beat in process");

  a_local_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.opcode == OP_RD_HOLD || in_data.opcode == OP_RD_COIL))
      |=> ##1 (out_valid_r && out_r.result_kind))
    else $error("local read gave no result");

  a_kind_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !pending_r |-> (kind_r == KIND_NONE))
    else $error("reply kind set with no reply pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result beat changed");
`endif

endmodule

// ===== bench/tb_modbus_rtu_slave.sv =====
module tb_modbus_rtu_slave;
  import mbrtu_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  modbus_rtu_slave DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] hold_regs [TBL_N];
  logic [15:0] inp_regs [TBL_N];
  logic        coils [TBL_N];
  logic        discretes [TBL_N];
  logic [7:0]  frame_head [6];
  logic [7:0]  frame_len;
  logic [15:0] frame_crc;
  logic        resp_busy;
  reply_kind_t resp_kind;
  logic [15:0] resp_pos;
  logic [15:0] resp_crc;
  logic [7:0]  unit_addr;

  out_item_t   expected_beats [$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_replies = 0;
  int unsigned cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic int unsigned head_word(int hi);
    return 32'({frame_head[hi], frame_head[hi + 1]});
  endfunction

  function automatic int unsigned reply_body_len();
    int unsigned cnt;
    cnt = head_word(4);
    if (resp_kind == KIND_BITS) return 3 + (cnt + 7) / 8;
    if (resp_kind == KIND_REGS) return 3 + 2 * cnt;
    if (resp_kind == KIND_ECHO) return 6;
    return 3;
  endfunction

  function automatic logic [7:0] reply_body_byte(int unsigned p);
    int unsigned addr, cnt, n, j;
    logic [7:0] acc;
    logic [15:0] v;
    addr = head_word(2);
    cnt = head_word(4);
    acc = 8'd0;
    if (p == 0) return frame_head[0];
    if (resp_kind == KIND_ECHO) return (p < 6) ? frame_head[p] : 8'd0;
    if (resp_kind >= KIND_EXC1) begin
      if (p == 1) return frame_head[1] | EXC_FLAG;
      return 8'(resp_kind - 3);
    end
    if (p == 1) return frame_head[1];
    if (resp_kind == KIND_BITS) begin
      if (p == 2) return 8'((cnt + 7) / 8);
      for (int i = 0; i < 8; i++) begin
        n = (p - 3) * 8 + i;
        if (n >= cnt || addr + n >= TBL_N) break;
        if ((frame_head[1] == FN_RD_COILS) ? coils[addr + n] : discretes[addr + n])
          acc[i] = 1'b1;
      end
      return acc;
    end
    if (p == 2) return 8'(2 * cnt);
    j = (p - 3) >> 1;
    if (addr + j >= TBL_N) return 8'd0;
    v = (frame_head[1] == FN_RD_HOLD) ? hold_regs[addr + j] : inp_regs[addr + j];
    return ((p - 3) & 1) ? v[7:0] : v[15:8];
  endfunction

  task automatic open_reply(reply_kind_t k);
    resp_busy = 1'b1;
    resp_kind = k;
    resp_pos = 16'd0;
    resp_crc = CRC_INIT;
  endtask

  // decide what a closed frame does
  task automatic close_frame();
    logic [7:0] len, fn;
    logic ok, bcast;
    int unsigned addr, val;
    len = frame_len;
    ok = !resp_busy && len >= MIN_FRAME && frame_crc == 16'd0 &&
         (frame_head[0] == unit_addr || frame_head[0] == 8'd0);
    frame_len = 8'd0;
    frame_crc = CRC_INIT;
    if (!ok) return;
    fn = frame_head[1];
    bcast = (frame_head[0] == 8'd0);
    if (bcast && fn != FN_WR_COIL && fn != FN_WR_HOLD) return;
    addr = head_word(2);
    val = head_word(4);
    if (fn >= FN_RD_COILS && fn <= FN_RD_INPUT) begin
      if (len != MIN_FRAME) return;
      if (val == 0 || addr >= TBL_N || val > TBL_N - addr) open_reply(KIND_EXC2);
      else open_reply(fn <= FN_RD_DISC ? KIND_BITS : KIND_REGS);
      return;
    end
    if (fn == FN_WR_COIL || fn == FN_WR_HOLD) begin
      if (len != MIN_FRAME) return;
      if (addr >= TBL_N) begin
        if (!bcast) open_reply(KIND_EXC2);
        return;
      end
      if (fn == FN_WR_COIL) begin
        if (val != COIL_OFF && val != COIL_ON) begin
          if (!bcast) open_reply(KIND_EXC3);
          return;
        end
        coils[addr] = (val == COIL_ON);
      end else begin
        hold_regs[addr] = 16'(val);
      end
      if (!bcast) open_reply(KIND_ECHO);
      return;
    end
    open_reply(KIND_EXC1);
  endtask

  // advance the predictor by one accepted beat
  task automatic predict_beat(in_item_t it);
    out_item_t r;
    int unsigned plen;
    r = '0;
    case (it.opcode)
      OP_RX_BYTE: begin
        if (frame_len < 6) frame_head[frame_len] = it.rx_byte;
        if (frame_len < RX_SAT) frame_len++;
        frame_crc = crc_byte(frame_crc, it.rx_byte);
      end
      OP_FRAME_END: close_frame();
      OP_TX_READY: begin
        if (resp_busy) begin
          plen = reply_body_len();
          if (resp_pos < plen) begin
            r.tx_byte = reply_body_byte(32'(resp_pos));
            resp_crc = crc_byte(resp_crc, r.tx_byte);
            resp_pos++;
          end else if (resp_pos == plen) begin
            r.tx_byte = resp_crc[7:0];
            resp_pos++;
          end else begin
            r.tx_byte = resp_crc[15:8];
            r.tx_last = 1'b1;
            resp_busy = 1'b0;
            resp_kind = KIND_NONE;
            resp_pos = 16'd0;
            n_replies++;
          end
          expected_beats.push_back(r);
        end
      end
      OP_SET_INPUT: inp_regs[it.local_index] = it.local_value;
      OP_SET_DISC: discretes[it.local_index] = it.local_value[0];
      OP_RD_HOLD, OP_RD_COIL: begin
        r.result_kind = 1'b1;
        r.read_value = (it.opcode == OP_RD_HOLD) ? hold_regs[it.local_index]
                                                 : {15'd0, coils[it.local_index]};
        expected_beats.push_back(r);
      end
      default: ;
    endcase
  endtask

  // send one beat, idling at random first
  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(it);
    n_sent++;
  endtask

  task automatic send_op(logic [2:0] op, logic [7:0] b, logic [4:0] idx, logic [15:0] v);
    in_item_t it;
    it.opcode = op;
    it.rx_byte = b;
    it.local_index = idx;
    it.local_value = v;
    send_beat(it);
  endtask

  // send a frame with CRC; corrupt flips the low bit of the last CRC byte
  task automatic send_frame(logic [7:0] bytes [$], bit corrupt);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (bytes[i]) begin
      send_op(OP_RX_BYTE, bytes[i], 5'($urandom), 16'($urandom));
      c = crc_byte(c, bytes[i]);
    end
    send_op(OP_RX_BYTE, c[7:0], 5'($urandom), 16'($urandom));
    send_op(OP_RX_BYTE, c[15:8] ^ (corrupt ? 8'h01 : 8'h00), 5'($urandom), 16'($urandom));
    send_op(OP_FRAME_END, 8'($urandom), 5'($urandom), 16'($urandom));
  endtask

  task automatic send_request(logic [7:0] unit, logic [7:0] fn, logic [15:0] a,
                              logic [15:0] v);
    send_frame('{unit, fn, a[15:8], a[7:0], v[15:8], v[7:0]}, 1'b0);
  endtask

  // clock out whatever reply is pending
  task automatic drain_reply();
    while (resp_busy) send_op(OP_TX_READY, 8'($urandom), 5'($urandom), 16'($urandom));
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_unit(logic [7:0] a);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    unit_addr = a;
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat %h", out_data);
          errors++;
        end else begin
          e = expected_beats.pop_front();
          n_checked++;
          if (out_data.result_kind !== e.result_kind) begin
            $error("result_kind exp %0d got %0d", e.result_kind, out_data.result_kind);
            errors++;
          end
          if (out_data.tx_byte !== e.tx_byte) begin
            $error("tx_byte exp %h got %h", e.tx_byte, out_data.tx_byte);
            errors++;
          end
          if (out_data.tx_last !== e.tx_last) begin
            $error("tx_last exp %0d got %0d", e.tx_last, out_data.tx_last);
            errors++;
          end
          if (out_data.read_value !== e.read_value) begin
            $error("read_value exp %h got %h", e.read_value, out_data.read_value);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("modbus_rtu_slave regression: fail");
      $finish;
    end
  end

  task automatic test_local_tables();
    send_op(OP_RD_HOLD, 8'h00, 5'd0, 16'h0000);
    send_op(OP_RD_COIL, 8'hFF, 5'd31, 16'hFFFF);
    send_op(OP_SET_INPUT, 8'h00, 5'd31, 16'hFFFF);
    send_op(OP_SET_INPUT, 8'h00, 5'd0, 16'h0000);
    send_op(OP_SET_DISC, 8'h00, 5'd31, 16'hFFFF);
    send_op(3'd7, 8'hFF, 5'd31, 16'hFFFF);
    send_op(OP_TX_READY, 8'h00, 5'd0, 16'h0000);
  endtask

  task automatic test_directed_frames();
    send_request(8'd1, FN_WR_HOLD, 16'd31, 16'hFFFF);
    drain_reply();
    send_request(8'd1, FN_RD_HOLD, 16'd30, 16'd2);
    drain_reply();
    send_request(8'd1, FN_WR_COIL, 16'd0, COIL_ON);
    drain_reply();
    send_request(8'd1, FN_WR_COIL, 16'd1, 16'h1234);
    drain_reply();
    send_request(8'd1, FN_RD_COILS, 16'd0, 16'd32);
    drain_reply();
    send_request(8'd1, FN_RD_DISC, 16'd0, 16'd0);
    drain_reply();
    send_request(8'd1, FN_RD_INPUT, 16'd31, 16'd2);
    drain_reply();
    send_request(8'd1, FN_WR_HOLD, 16'd32, 16'd5);
    drain_reply();
    send_request(8'd1, 8'd7, 16'd0, 16'd1);
    drain_reply();
    send_request(8'd0, FN_WR_HOLD, 16'd3, 16'hABCD);
    send_request(8'd0, FN_RD_HOLD, 16'd0, 16'd1);
    send_request(8'd9, FN_RD_HOLD, 16'd0, 16'd1);
    send_frame('{8'd1, FN_RD_HOLD, 8'd0, 8'd0, 8'd0, 8'd1}, 1'b1);
    send_frame('{8'd1, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd1, 8'hAA}, 1'b0);
    send_frame('{8'd1, FN_RD_HOLD, 8'd0}, 1'b0);
    send_request(8'd1, FN_RD_HOLD, 16'd3, 16'd1);
    // frame while reply pending is dropped
    send_request(8'd1, FN_WR_HOLD, 16'd4, 16'd4);
    drain_reply();
    send_op(OP_RD_HOLD, 8'd0, 5'd4, 16'd0);
    send_op(OP_RD_HOLD, 8'd0, 5'd3, 16'd0);
  endtask

  // 256-byte frame with a good CRC: the length must saturate, not wrap
  task automatic test_long_frame();
    logic [7:0] body [$];
    body.push_back(unit_addr);
    body.push_back(8'd7);
    repeat (252) body.push_back(8'($urandom));
    send_frame(body, 1'b0);
    drain_reply();
  endtask

  task automatic random_request();
    logic [7:0] unit, fn;
    logic [15:0] a, v;
    int sel;
    sel = $urandom_range(99);
    unit = (sel < 75) ? unit_addr : (sel < 88) ? 8'd0 : 8'($urandom);
    fn = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6, 1));
    a = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(33));
    case ($urandom_range(3))
      0: v = 16'($urandom);
      1: v = $urandom_range(1) ? COIL_ON : COIL_OFF;
      default: v = 16'($urandom_range(34));
    endcase
    if ($urandom_range(9) == 0) send_frame('{unit, fn, a[15:8], a[7:0], v[15:8]}, 1'b0);
    else send_frame('{unit, fn, a[15:8], a[7:0], v[15:8], v[7:0]},
                    $urandom_range(14) == 0);
    // interleave local beats with the reply bytes
    while (resp_busy) begin
      if ($urandom_range(4) == 0)
        send_op(3'($urandom_range(6, 3)), 8'($urandom), 5'($urandom), 16'($urandom));
      else send_op(OP_TX_READY, 8'($urandom), 5'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_random(int target);
    int stop;
    stop = n_sent + target;
    while (n_sent < stop) begin
      if ($urandom_range(9) < 7) random_request();
      else send_op(3'($urandom_range(7)), 8'($urandom), 5'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    foreach (hold_regs[i]) begin
      hold_regs[i] = '0; inp_regs[i] = '0; coils[i] = 1'b0; discretes[i] = 1'b0;
    end
    foreach (frame_head[i]) frame_head[i] = '0;
    frame_len = '0;
    frame_crc = CRC_INIT;
    resp_busy = 1'b0;
    resp_kind = KIND_NONE;
    resp_pos = 16'd0;
    resp_crc = CRC_INIT;
    unit_addr = 8'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_local_tables();
    test_directed_frames();
    test_long_frame();
    set_unit(8'd247);
    test_random(20);
    send_idle_pct = 51;
    set_unit(8'd1);
    test_random(20);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    set_unit(8'($urandom_range(246, 2)));
    test_random(20);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    set_unit(8'd247);
    test_random(20);

    wait_quiet();
    $display("sent %0d beats, checked %0d results, %0d reply frames", n_sent, n_checked,
             n_replies);
    $display("covered local tables, all functions, exceptions, broadcast, bad and long frames");
    if (errors == 0 && expected_beats.size() == 0)
      $display("modbus_rtu_slave regression: pass");
    else
      $display("modbus_rtu_slave regression: fail");
    $finish;
  end

endmodule
